@@ rtl/blop_pkg.sv @@
package blop_pkg;

    // Lattice size limits.
    localparam int DEF_MAX_STEPS = 30;
    localparam logic [4:0] CFG_RESET_STEPS = 5'd30;

    // Fixed-point constants (Q16.16 unless noted).
    localparam logic [16:0] ONE_Q16 = 17'd65536;
    localparam logic [31:0] VOL_FLOOR = 32'd7;
    localparam logic [31:0] LN2_Q32 = 32'd2977044472;
    localparam logic [19:0] EXP_LIMIT = 20'd786432;
    localparam logic [3:0] EXP_LAST_TERM = 4'd14;

    // Result status codes.
    localparam logic [1:0] STAT_OK = 2'd0;
    localparam logic [1:0] STAT_SAT = 2'd1;
    localparam logic [1:0] STAT_ZERO_EXPIRY = 2'd2;

    // Shared divider: dividend width and iteration count width.
    localparam int DIV_W = 49;
    localparam int DIV_CNT_W = 6;

    typedef struct packed {
        logic                 start;
        logic [DIV_CNT_W-1:0] count;
        logic [DIV_W-1:0]     dividend;
        logic [31:0]          divisor;
    } div_req_t;

    typedef struct packed {
        logic             busy;
        logic             done;
        logic [DIV_W-1:0] quotient;
    } div_rsp_t;

endpackage

@@ rtl/blop_ram.sv @@
module blop_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // One write port and one registered read port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/blop_div.sv @@
module blop_div
    import blop_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic [DIV_W-1:0]     q_reg;
    logic [31:0]          r_reg;
    logic [31:0]          dvs_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;
    logic [32:0]          trial;
    logic                 ge;
    logic [32:0]          diff;

    // One restoring step: bring down the next dividend bit and try a subtract.
    always_comb begin
        trial = {r_reg, q_reg[DIV_W-1]};
        ge    = trial >= {1'b0, dvs_reg};
        diff  = trial - {1'b0, dvs_reg};
    end

    // The dividend is left-aligned so that only count steps are needed.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                q_reg    <= req.dividend << (DIV_CNT_W'(DIV_W) - req.count);
                r_reg    <= '0;
                dvs_reg  <= req.divisor;
                cnt_reg  <= req.count;
                busy_reg <= 1'b1;
            end else if (busy_reg) begin
                r_reg   <= ge ? diff[31:0] : trial[31:0];
                q_reg   <= {q_reg[DIV_W-2:0], ge};
                cnt_reg <= cnt_reg - DIV_CNT_W'(1);
                if (cnt_reg == DIV_CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign rsp.busy     = busy_reg;
    assign rsp.done     = done_reg;
    assign rsp.quotient = q_reg;

endmodule

@@ rtl/binomial_lattice_option_pricer.sv @@
// Timing per option is set mostly by the node sweep (S_N_RD, S_N_M1, S_N_M2, S_N_M3 and
// S_N_WR for each node, on the shared multiplier and the one-read node memory) and by
// the exponentials, three or two for futures style (fourteen Taylor terms, each through
// the 32-step divider). Zero expiry goes straight to S_OUT; its word enters the output
// register once that is free. s_tready is high only while no option is in work.
// Reset: synchronous, active low; the steps register returns to 30, no word is pending.
module binomial_lattice_option_pricer
    import blop_pkg::*;
#(
    parameter int MAX_STEPS = DEF_MAX_STEPS
) (
    input  logic         aclk,
    input  logic         aresetn,
    // Configuration: number of lattice steps.
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [4:0]   cfg_data,
    // Input option word.
    input  logic         s_tvalid,
    output logic         s_tready,
    // [31:0] spot_price, [63:32] strike_price, [95:64] time_to_expiry,
    // [127:96] volatility, [159:128] interest_rate
    input  logic [159:0] s_tdata,
    // [0] is_put, [1] is_futures_style, [2] is_american
    input  logic [2:0]   s_tuser,
    // Result word.
    output logic         m_tvalid,
    input  logic         m_tready,
    // [31:0] option_price, [33:32] status, [39:34] zero
    output logic [39:0]  m_tdata
);

    localparam int N_W = $clog2(MAX_STEPS + 1);
    localparam int PRICE_DEPTH = 2 * MAX_STEPS + 1;
    localparam int PA_W = $clog2(PRICE_DEPTH);

    typedef enum logic [5:0] {
        S_IDLE, S_DT, S_DT_W, S_SQ, S_X_M, S_X,
        S_EXP_INIT, S_EXP_RED, S_EXP_TM, S_EXP_TD, S_EXP_TW, S_EXP_FIN,
        S_D, S_D_W, S_R_M, S_R, S_P, S_P_W,
        S_PR0, S_PR_M, S_PR_W, S_LF_RD, S_LF_WR, S_LV_RD, S_LV_CAP,
        S_N_RD, S_N_M1, S_N_M2, S_N_M3, S_N_WR, S_OUT
    } state_t;

    typedef enum logic [1:0] {EXP_UP, EXP_GROWTH, EXP_DISC} exp_sel_t;

    state_t           state_reg;
    exp_sel_t         exp_sel_reg;
    logic [4:0]       steps_reg;
    logic             put_reg, fut_reg, amer_reg;
    logic [31:0]      spot_reg, strike_reg, tex_reg, vol_reg, rate_reg;
    logic [N_W-1:0]   n_reg, j_reg, k_reg;
    logic [31:0]      dt_reg;
    logic [47:0]      sq_v_reg, sq_res_reg, sq_bit_reg;
    logic [4:0]       sq_cnt_reg;
    logic [31:0]      u_reg, d_reg, a_reg, disc_reg;
    logic [16:0]      p_reg;
    logic             rdt_neg_reg;
    logic [47:0]      rdt_mag_reg;
    logic             exp_neg_reg;
    logic [47:0]      exp_mag_reg;
    logic signed [37:0] ex_rem_reg;
    logic signed [5:0]  ex_k_reg;
    logic [32:0]      ex_term_reg;
    logic [33:0]      ex_acc_reg;
    logic [3:0]       ex_i_reg;
    logic             sat_reg;
    logic [64:0]      prod_reg;
    logic [31:0]      prev_reg;
    logic             up_chain_reg;
    logic [31:0]      vup_reg, vdn_reg, iv_reg;
    logic [48:0]      acc_reg;
    logic [31:0]      fin_price_reg, out_price_reg;
    logic [1:0]       fin_status_reg, out_status_reg;
    logic             m_valid_reg;

    div_req_t         div_req;
    div_rsp_t         div_rsp;

    logic [32:0]      mul_a;
    logic [31:0]      mul_b;
    logic [N_W-1:0]   n_clamp;
    logic [31:0]      rate_mag;
    logic [19:0]      x_clamp;
    logic [48:0]      x_raw;
    logic [47:0]      sq_sum;
    logic [32:0]      ms;
    logic [48:0]      c_sum;
    logic [31:0]      cv;
    logic [35:0]      ex_v;
    logic [5:0]       ex_s;
    logic [31:0]      ex_res;
    logic             ex_sat;
    logic signed [33:0] num;
    logic [31:0]      node_val;

    logic             node_we;
    logic [N_W-1:0]   node_waddr, node_raddr;
    logic [31:0]      node_wdata, node_rdata;
    logic             price_we;
    logic [PA_W-1:0]  price_waddr, price_raddr;
    logic [31:0]      price_wdata, price_rdata;

    // Intrinsic value of the option at an asset price.
    function automatic logic [31:0] payoff(input logic put, input logic [31:0] s,
                                           input logic [31:0] k);
        if (put) begin
            return (k > s) ? k - s : 32'd0;
        end
        return (s > k) ? s - k : 32'd0;
    endfunction

    // Rounded Q16.16 product, saturated to 32 bits; the top bit flags saturation.
    function automatic logic [32:0] mul_sat(input logic [64:0] p);
        logic [64:0] r;
        r = p + 65'd32768;
        if (|r[64:48]) begin
            return {1'b1, 32'hFFFF_FFFF};
        end
        return {1'b0, r[47:16]};
    endfunction

    blop_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    blop_ram #(.WIDTH(32), .DEPTH(MAX_STEPS + 1)) u_node_ram (
        .aclk  (aclk),
        .we    (node_we),
        .waddr (node_waddr),
        .wdata (node_wdata),
        .raddr (node_raddr),
        .rdata (node_rdata)
    );

    blop_ram #(.WIDTH(32), .DEPTH(PRICE_DEPTH)) u_price_ram (
        .aclk  (aclk),
        .we    (price_we),
        .waddr (price_waddr),
        .wdata (price_wdata),
        .raddr (price_raddr),
        .rdata (price_rdata)
    );

    // Configuration register; always ready.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            steps_reg <= CFG_RESET_STEPS;
        end else if (cfg_valid) begin
            steps_reg <= cfg_data;
        end
    end

    // Step count clamped to the lattice range.
    always_comb begin
        if (steps_reg == 5'd0) begin
            n_clamp = N_W'(1);
        end else if (int'(steps_reg) > MAX_STEPS) begin
            n_clamp = N_W'(MAX_STEPS);
        end else begin
            n_clamp = N_W'(steps_reg);
        end
    end

    // Arithmetic helpers around the shared multiplier and the exponential.
    always_comb begin
        rate_mag = rate_reg[31] ? 32'(-rate_reg) : rate_reg;
        x_raw    = prod_reg[64:16];
        if (x_raw == 49'd0) begin
            x_clamp = 20'd1;
        end else if (x_raw > 49'(EXP_LIMIT)) begin
            x_clamp = EXP_LIMIT;
        end else begin
            x_clamp = x_raw[19:0];
        end
        sq_sum = sq_res_reg + sq_bit_reg;
        ms     = mul_sat(prod_reg);
        c_sum  = acc_reg + prod_reg[48:0] + 49'd32768;
        cv     = c_sum[47:16];
        ex_s   = 6'(6'sd16 - ex_k_reg);
        if (ex_k_reg >= 6'sd16) begin
            ex_v = {2'b0, ex_acc_reg} << 6'(ex_k_reg - 6'sd16);
        end else begin
            ex_v = ({2'b0, ex_acc_reg} + (36'd1 << (ex_s - 6'd1))) >> ex_s;
        end
        ex_sat = |ex_v[35:32];
        ex_res = ex_sat ? 32'hFFFF_FFFF : ex_v[31:0];
        num    = $signed({2'b0, a_reg}) - $signed({2'b0, d_reg});
        node_val = (amer_reg && (iv_reg > ms[31:0])) ? iv_reg : ms[31:0];
    end

    // Operand selection for the shared multiplier.
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            S_X_M: begin
                mul_a = 33'(vol_reg);
                mul_b = sq_res_reg[31:0];
            end
            S_EXP_TM: begin
                mul_a = ex_term_reg;
                mul_b = ex_rem_reg[31:0];
            end
            S_R_M: begin
                mul_a = 33'(rate_mag);
                mul_b = dt_reg;
            end
            S_PR_M: begin
                mul_a = 33'(prev_reg);
                mul_b = up_chain_reg ? u_reg : d_reg;
            end
            S_N_M1: begin
                mul_a = 33'(p_reg);
                mul_b = node_rdata;
            end
            S_N_M2: begin
                mul_a = 33'(ONE_Q16 - p_reg);
                mul_b = vdn_reg;
            end
            S_N_M3: begin
                mul_a = 33'(cv);
                mul_b = disc_reg;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Registered product.
    always_ff @(posedge aclk) begin
        prod_reg <= 65'(mul_a) * 65'(mul_b);
    end

    // Divider requests.
    always_comb begin
        div_req = '0;
        unique case (state_reg)
            S_DT: begin
                div_req.start    = 1'b1;
                div_req.count    = DIV_CNT_W'(32);
                div_req.dividend = DIV_W'(tex_reg);
                div_req.divisor  = 32'(n_reg);
            end
            S_EXP_TD: begin
                div_req.start    = 1'b1;
                div_req.count    = DIV_CNT_W'(32);
                div_req.dividend = DIV_W'(prod_reg[63:32]);
                div_req.divisor  = 32'(ex_i_reg);
            end
            S_D: begin
                div_req.start    = 1'b1;
                div_req.count    = DIV_CNT_W'(33);
                div_req.dividend = DIV_W'(1) << 32;
                div_req.divisor  = u_reg;
            end
            S_P: begin
                div_req.start    = (num > 34'sd0);
                div_req.count    = DIV_CNT_W'(DIV_W);
                div_req.dividend = DIV_W'({num[31:0], 16'd0});
                div_req.divisor  = u_reg - d_reg;
            end
            default: begin
                div_req = '0;
            end
        endcase
    end

    // Memory ports.
    always_comb begin
        node_we     = 1'b0;
        node_waddr  = j_reg;
        node_wdata  = node_val;
        node_raddr  = '0;
        price_we    = 1'b0;
        price_waddr = PA_W'(MAX_STEPS);
        price_wdata = ms[31:0];
        price_raddr = '0;
        unique case (state_reg)
            S_PR0: begin
                price_we    = 1'b1;
                price_wdata = spot_reg;
            end
            S_PR_W: begin
                price_we    = 1'b1;
                price_waddr = up_chain_reg ? PA_W'(MAX_STEPS + int'(j_reg))
                                           : PA_W'(MAX_STEPS - int'(j_reg));
            end
            S_LF_RD: begin
                price_raddr = PA_W'(MAX_STEPS + 2 * int'(j_reg) - int'(n_reg));
            end
            S_LF_WR: begin
                node_we    = 1'b1;
                node_wdata = payoff(put_reg, price_rdata, strike_reg);
            end
            S_N_RD: begin
                node_raddr  = j_reg + N_W'(1);
                price_raddr = PA_W'(MAX_STEPS + 2 * int'(j_reg) + 1 - int'(k_reg));
            end
            S_N_WR: begin
                node_we = 1'b1;
            end
            default: begin
                node_we  = 1'b0;
                price_we = 1'b0;
            end
        endcase
    end

    // Sequencer.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            // The output register is refilled when free or drained in the same cycle.
            if ((state_reg == S_OUT) && (!m_valid_reg || m_tready)) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (s_tvalid) begin
                        put_reg    <= s_tuser[0];
                        fut_reg    <= s_tuser[1];
                        amer_reg   <= s_tuser[2];
                        spot_reg   <= s_tdata[31:0];
                        strike_reg <= s_tdata[63:32];
                        tex_reg    <= s_tdata[95:64];
                        vol_reg    <= (s_tdata[127:96] < VOL_FLOOR) ? VOL_FLOOR
                                                                    : s_tdata[127:96];
                        rate_reg   <= s_tdata[159:128];
                        n_reg      <= n_clamp;
                        sat_reg    <= 1'b0;
                        if (s_tdata[95:64] == 32'd0) begin
                            fin_price_reg  <= 32'd0;
                            fin_status_reg <= STAT_ZERO_EXPIRY;
                            state_reg      <= S_OUT;
                        end else begin
                            state_reg <= S_DT;
                        end
                    end
                end
                S_DT: begin
                    state_reg <= S_DT_W;
                end
                S_DT_W: begin
                    if (div_rsp.done) begin
                        dt_reg     <= div_rsp.quotient[31:0];
                        sq_v_reg   <= {div_rsp.quotient[31:0], 16'd0};
                        sq_res_reg <= '0;
                        sq_bit_reg <= 48'd1 << 46;
                        sq_cnt_reg <= '0;
                        state_reg  <= S_SQ;
                    end
                end
                // Integer square root, one result bit per cycle.
                S_SQ: begin
                    if (sq_v_reg >= sq_sum) begin
                        sq_v_reg   <= sq_v_reg - sq_sum;
                        sq_res_reg <= (sq_res_reg >> 1) + sq_bit_reg;
                    end else begin
                        sq_res_reg <= sq_res_reg >> 1;
                    end
                    sq_bit_reg <= sq_bit_reg >> 2;
                    sq_cnt_reg <= sq_cnt_reg + 5'd1;
                    if (sq_cnt_reg == 5'd23) begin
                        state_reg <= S_X_M;
                    end
                end
                S_X_M: begin
                    state_reg <= S_X;
                end
                S_X: begin
                    exp_neg_reg <= 1'b0;
                    exp_mag_reg <= 48'(x_clamp);
                    exp_sel_reg <= EXP_UP;
                    state_reg   <= S_EXP_INIT;
                end
                // Exponential: clamp, reduce by ln2, Taylor sum, scale.
                S_EXP_INIT: begin
                    if (exp_mag_reg > 48'(EXP_LIMIT)) begin
                        ex_rem_reg <= exp_neg_reg ? -$signed(38'({EXP_LIMIT, 16'd0}))
                                                  : $signed(38'({EXP_LIMIT, 16'd0}));
                    end else begin
                        ex_rem_reg <= exp_neg_reg ? -$signed(38'({exp_mag_reg[19:0], 16'd0}))
                                                  : $signed(38'({exp_mag_reg[19:0], 16'd0}));
                    end
                    ex_k_reg  <= '0;
                    state_reg <= S_EXP_RED;
                end
                S_EXP_RED: begin
                    if (ex_rem_reg < 38'sd0) begin
                        ex_rem_reg <= ex_rem_reg + $signed({6'd0, LN2_Q32});
                        ex_k_reg   <= ex_k_reg - 6'sd1;
                    end else if (ex_rem_reg >= $signed({6'd0, LN2_Q32})) begin
                        ex_rem_reg <= ex_rem_reg - $signed({6'd0, LN2_Q32});
                        ex_k_reg   <= ex_k_reg + 6'sd1;
                    end else begin
                        ex_term_reg <= 33'd1 << 32;
                        ex_acc_reg  <= 34'd1 << 32;
                        ex_i_reg    <= 4'd1;
                        state_reg   <= S_EXP_TM;
                    end
                end
                S_EXP_TM: begin
                    state_reg <= S_EXP_TD;
                end
                S_EXP_TD: begin
                    state_reg <= S_EXP_TW;
                end
                S_EXP_TW: begin
                    if (div_rsp.done) begin
                        ex_term_reg <= div_rsp.quotient[32:0];
                        ex_acc_reg  <= ex_acc_reg + 34'(div_rsp.quotient[32:0]);
                        if (ex_i_reg == EXP_LAST_TERM) begin
                            state_reg <= S_EXP_FIN;
                        end else begin
                            ex_i_reg  <= ex_i_reg + 4'd1;
                            state_reg <= S_EXP_TM;
                        end
                    end
                end
                S_EXP_FIN: begin
                    sat_reg <= sat_reg | ex_sat;
                    unique case (exp_sel_reg)
                        EXP_UP: begin
                            u_reg     <= ex_res;
                            state_reg <= S_D;
                        end
                        EXP_GROWTH: begin
                            a_reg       <= ex_res;
                            exp_neg_reg <= !rdt_neg_reg;
                            exp_mag_reg <= rdt_mag_reg;
                            exp_sel_reg <= EXP_DISC;
                            state_reg   <= S_EXP_INIT;
                        end
                        EXP_DISC: begin
                            disc_reg  <= ex_res;
                            state_reg <= S_P;
                        end
                        default: begin
                            state_reg <= S_IDLE;
                        end
                    endcase
                end
                S_D: begin
                    state_reg <= S_D_W;
                end
                S_D_W: begin
                    if (div_rsp.done) begin
                        d_reg     <= div_rsp.quotient[31:0];
                        state_reg <= S_R_M;
                    end
                end
                S_R_M: begin
                    state_reg <= S_R;
                end
                // r*dt, truncated toward zero, kept as sign and magnitude.
                S_R: begin
                    rdt_neg_reg <= rate_reg[31];
                    rdt_mag_reg <= prod_reg[63:16];
                    exp_mag_reg <= prod_reg[63:16];
                    if (fut_reg) begin
                        a_reg       <= 32'(ONE_Q16);
                        exp_neg_reg <= !rate_reg[31];
                        exp_sel_reg <= EXP_DISC;
                    end else begin
                        exp_neg_reg <= rate_reg[31];
                        exp_sel_reg <= EXP_GROWTH;
                    end
                    state_reg <= S_EXP_INIT;
                end
                // Up probability, clamped to [0, 1].
                S_P: begin
                    if (num > 34'sd0) begin
                        state_reg <= S_P_W;
                    end else begin
                        p_reg     <= '0;
                        state_reg <= S_PR0;
                    end
                end
                S_P_W: begin
                    if (div_rsp.done) begin
                        p_reg <= (div_rsp.quotient > DIV_W'(ONE_Q16)) ? ONE_Q16
                                                                     : div_rsp.quotient[16:0];
                        state_reg <= S_PR0;
                    end
                end
                // Asset price table: spot in the middle, up and down chains around it.
                S_PR0: begin
                    prev_reg     <= spot_reg;
                    j_reg        <= N_W'(1);
                    up_chain_reg <= 1'b1;
                    state_reg    <= S_PR_M;
                end
                S_PR_M: begin
                    state_reg <= S_PR_W;
                end
                S_PR_W: begin
                    sat_reg <= sat_reg | ms[32];
                    if (j_reg == n_reg) begin
                        if (up_chain_reg) begin
                            up_chain_reg <= 1'b0;
                            prev_reg     <= spot_reg;
                            j_reg        <= N_W'(1);
                            state_reg    <= S_PR_M;
                        end else begin
                            j_reg     <= '0;
                            state_reg <= S_LF_RD;
                        end
                    end else begin
                        prev_reg  <= ms[31:0];
                        j_reg     <= j_reg + N_W'(1);
                        state_reg <= S_PR_M;
                    end
                end
                // Leaf payoffs.
                S_LF_RD: begin
                    state_reg <= S_LF_WR;
                end
                S_LF_WR: begin
                    if (j_reg == n_reg) begin
                        k_reg     <= n_reg;
                        j_reg     <= '0;
                        state_reg <= S_LV_RD;
                    end else begin
                        j_reg     <= j_reg + N_W'(1);
                        state_reg <= S_LF_RD;
                    end
                end
                // Backward induction, one node at a time.
                S_LV_RD: begin
                    state_reg <= S_LV_CAP;
                end
                S_LV_CAP: begin
                    vdn_reg   <= node_rdata;
                    state_reg <= S_N_RD;
                end
                S_N_RD: begin
                    state_reg <= S_N_M1;
                end
                S_N_M1: begin
                    vup_reg   <= node_rdata;
                    iv_reg    <= payoff(put_reg, price_rdata, strike_reg);
                    state_reg <= S_N_M2;
                end
                S_N_M2: begin
                    acc_reg   <= prod_reg[48:0];
                    state_reg <= S_N_M3;
                end
                S_N_M3: begin
                    state_reg <= S_N_WR;
                end
                S_N_WR: begin
                    sat_reg <= sat_reg | ms[32];
                    vdn_reg <= vup_reg;
                    if (j_reg == k_reg - N_W'(1)) begin
                        if (k_reg == N_W'(1)) begin
                            fin_price_reg  <= node_val;
                            fin_status_reg <= (sat_reg | ms[32]) ? STAT_SAT : STAT_OK;
                            state_reg      <= S_OUT;
                        end else begin
                            k_reg     <= k_reg - N_W'(1);
                            j_reg     <= '0;
                            state_reg <= S_LV_RD;
                        end
                    end else begin
                        j_reg     <= j_reg + N_W'(1);
                        state_reg <= S_N_RD;
                    end
                end
                // Hand the result to the output register once it is free.
                S_OUT: begin
                    if (!m_valid_reg || m_tready) begin
                        out_price_reg  <= fin_price_reg;
                        out_status_reg <= fin_status_reg;
                        state_reg      <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {6'd0, out_status_reg, out_price_reg};

    // The divider is never restarted while it is still iterating.
    a_div_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        div_req.start |-> !div_rsp.busy)
        else $error("divider started while busy");

    // The up probability stays within [0, 1] during the node sweep.
    a_prob_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_N_M1) |-> (p_reg <= ONE_Q16))
        else $error("up probability out of range");

    // Node writes stay inside the active lattice.
    a_node_addr: assert property (@(posedge aclk) disable iff (!aresetn)
        node_we |-> (node_waddr <= n_reg))
        else $error("node write beyond lattice");

    // A zero-expiry result always carries a zero price.
    a_zero_expiry: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && (out_status_reg == STAT_ZERO_EXPIRY)) |-> (out_price_reg == 32'd0))
        else $error("zero expiry with nonzero price");

endmodule

@@ test/binomial_lattice_option_pricer_tb.sv @@
`timescale 1ns / 1ps

module binomial_lattice_option_pricer_tb;
    import blop_pkg::*;

    localparam longint CYCLE_LIMIT = 40_000_000;
    localparam int RANDOM_OPTIONS = 750;

    typedef struct {
        logic        is_put;
        logic        is_futures_style;
        logic        is_american;
        logic [31:0] spot_price;
        logic [31:0] strike_price;
        logic [31:0] time_to_expiry;
        logic [31:0] volatility;
        logic [31:0] interest_rate;
    } option_t;

    typedef struct {
        logic [31:0] option_price;
        logic [1:0]  status;
    } price_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         cfg_valid = 1'b0;
    logic         cfg_ready;
    logic [4:0]   cfg_data = '0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [159:0] s_tdata = '0;
    logic [2:0]   s_tuser = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [39:0]  m_tdata;

    // Model state: the steps register and the prices still owed by the block.
    logic [4:0]   model_steps = CFG_RESET_STEPS;
    price_t       pending_prices[$];
    int           error_count = 0;
    int           options_sent = 0;
    int           prices_checked = 0;
    longint       cycle_count = 0;
    int           hold_off_request = 0;
    bit           stall_enable = 1'b1;

    binomial_lattice_option_pricer i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always #5 aclk = ~aclk;

    // Integer square root, bit by bit.
    function automatic longint unsigned int_sqrt(input longint unsigned v);
        longint unsigned res;
        longint unsigned bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v = v - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // Rounded Q16.16 product that saturates at all ones.
    function automatic logic [31:0] q16_mul(input logic [31:0] a, input logic [31:0] b,
                                            inout bit sat);
        longint unsigned v;
        v = (longint'(a) * longint'(b) + 64'd32768) >> 16;
        if (v > 64'hFFFF_FFFF) begin
            sat = 1'b1;
            return 32'hFFFF_FFFF;
        end
        return v[31:0];
    endfunction

    // Exponential: range reduction by ln2, Taylor series in Q32, rescale to Q16.16.
    function automatic logic [31:0] q16_exp(input longint x, inout bit sat);
        longint ln2;
        longint xs;
        longint k;
        longint rem;
        longint unsigned term;
        longint unsigned acc;
        longint unsigned v;
        int s;
        ln2 = longint'(LN2_Q32);
        if (x > longint'(EXP_LIMIT)) x = longint'(EXP_LIMIT);
        if (x < -longint'(EXP_LIMIT)) x = -longint'(EXP_LIMIT);
        xs = x * 65536;
        k = xs / ln2;
        rem = xs - k * ln2;
        if (rem < 0) begin
            rem = rem + ln2;
            k = k - 1;
        end
        term = 64'd1 << 32;
        acc = term;
        for (int i = 1; i <= int'(EXP_LAST_TERM); i++) begin
            term = ((term * longint'(unsigned'(rem))) >> 32) / i;
            acc = acc + term;
        end
        if (k >= 16) begin
            v = acc << (k - 16);
        end else begin
            s = 16 - k;
            v = (acc + (64'd1 << (s - 1))) >> s;
        end
        if (v > 64'hFFFF_FFFF) begin
            sat = 1'b1;
            return 32'hFFFF_FFFF;
        end
        return v[31:0];
    endfunction

    function automatic logic [31:0] exercise_value(input logic put, input logic [31:0] s,
                                                   input logic [31:0] k);
        if (put) return (k > s) ? k - s : 32'd0;
        return (s > k) ? s - k : 32'd0;
    endfunction

    // Price one option on the CRR lattice with the given steps setting.
    function automatic price_t lattice_price(input option_t o, input logic [4:0] steps);
        price_t r;
        bit sat;
        int n;
        logic [31:0] vol;
        logic [31:0] dt;
        logic [31:0] upf;
        logic [31:0] dnf;
        logic [31:0] growth;
        logic [31:0] disc;
        logic [31:0] prob;
        longint unsigned sq;
        longint unsigned x;
        longint unsigned v;
        longint rdt;
        longint num;
        logic [31:0] up_path[0:30];
        logic [31:0] dn_path[0:30];
        logic [31:0] node[0:30];
        longint unsigned c;
        logic [31:0] cont;
        logic [31:0] val;
        logic [31:0] s;
        int e;
        sat = 1'b0;
        if (o.time_to_expiry == 0) begin
            r.option_price = '0;
            r.status = STAT_ZERO_EXPIRY;
            return r;
        end
        n = steps;
        if (n < 1) n = 1;
        if (n > DEF_MAX_STEPS) n = DEF_MAX_STEPS;
        vol = (o.volatility < VOL_FLOOR) ? VOL_FLOOR : o.volatility;
        dt = o.time_to_expiry / n;
        sq = int_sqrt(longint'(dt) << 16);
        x = (longint'(vol) * sq) >> 16;
        if (x == 0) x = 1;
        if (x > longint'(EXP_LIMIT)) x = longint'(EXP_LIMIT);
        upf = q16_exp(longint'(x), sat);
        v = (64'd1 << 32) / longint'(upf);
        dnf = v[31:0];
        rdt = (longint'(signed'(o.interest_rate)) * longint'(dt)) / 65536;
        growth = o.is_futures_style ? 32'(ONE_Q16) : q16_exp(rdt, sat);
        disc = q16_exp(-rdt, sat);
        num = longint'(growth) - longint'(dnf);
        if (num <= 0) begin
            prob = 0;
        end else begin
            v = (longint'(num) << 16) / longint'(upf - dnf);
            prob = (v > 64'd65536) ? 32'd65536 : v[31:0];
        end
        up_path[0] = o.spot_price;
        dn_path[0] = o.spot_price;
        for (int j = 1; j <= n; j++) begin
            up_path[j] = q16_mul(up_path[j-1], upf, sat);
            dn_path[j] = q16_mul(dn_path[j-1], dnf, sat);
        end
        for (int j = 0; j <= n; j++) begin
            e = 2 * j - n;
            s = (e >= 0) ? up_path[e] : dn_path[-e];
            node[j] = exercise_value(o.is_put, s, o.strike_price);
        end
        // Backward induction, with the early exercise check for American options.
        for (int k = n; k > 0; k--) begin
            for (int j = 0; j < k; j++) begin
                c = longint'(prob) * longint'(node[j+1])
                  + longint'(32'd65536 - prob) * longint'(node[j]);
                v = (c + 64'd32768) >> 16;
                cont = v[31:0];
                val = q16_mul(cont, disc, sat);
                if (o.is_american) begin
                    e = 2 * j - (k - 1);
                    s = (e >= 0) ? up_path[e] : dn_path[-e];
                    if (exercise_value(o.is_put, s, o.strike_price) > val)
                        val = exercise_value(o.is_put, s, o.strike_price);
                end
                node[j] = val;
            end
        end
        r.option_price = node[0];
        r.status = sat ? STAT_SAT : STAT_OK;
        return r;
    endfunction

    // Input side: each accepted word owes one price; config words change the model.
    always @(posedge aclk) begin
        if (aresetn && cfg_valid && cfg_ready) model_steps <= cfg_data;
        if (aresetn && s_tvalid && s_tready) begin
            option_t o;
            o.spot_price       = s_tdata[31:0];
            o.strike_price     = s_tdata[63:32];
            o.time_to_expiry   = s_tdata[95:64];
            o.volatility       = s_tdata[127:96];
            o.interest_rate    = s_tdata[159:128];
            o.is_put           = s_tuser[0];
            o.is_futures_style = s_tuser[1];
            o.is_american      = s_tuser[2];
            pending_prices.push_back(lattice_price(o, model_steps));
            options_sent++;
        end
    end

    // Output side: compare each result word against the oldest pending price.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            price_t want;
            if (pending_prices.size() == 0) begin
                $display("%0t: result word with no price pending: %h", $time, m_tdata);
                error_count++;
            end else begin
                want = pending_prices.pop_front();
                prices_checked++;
                if (m_tdata[31:0] !== want.option_price) begin
                    $display("%0t: option_price expected %h actual %h", $time,
                             want.option_price, m_tdata[31:0]);
                    error_count++;
                end
                if (m_tdata[33:32] !== want.status) begin
                    $display("%0t: status expected %0d actual %0d", $time,
                             want.status, m_tdata[33:32]);
                    error_count++;
                end
            end
        end
    end

    // Receiver: random stalls, plus a long hold-off when a test asks for one.
    always @(posedge aclk) begin
        int hold;
        if (hold_off_request > 0) begin
            hold = hold_off_request;
            hold_off_request = 0;
            m_tready <= 1'b0;
            repeat (hold) @(posedge aclk);
            m_tready <= 1'b1;
        end else if (!stall_enable) begin
            m_tready <= 1'b1;
        end else if ($urandom_range(0, 99) < 20) begin
            m_tready <= 1'b0;
            if ($urandom_range(0, 19) == 0) repeat ($urandom_range(50, 400)) @(posedge aclk);
            else repeat ($urandom_range(0, 4)) @(posedge aclk);
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Watchdog.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d prices pending", cycle_count,
                     pending_prices.size());
            $display("binomial_lattice_option_pricer_tb NOT OK");
            $finish;
        end
    end

    // Offer one option word, after an optional idle gap, and wait until it is taken.
    task automatic send_option(input option_t o, input bit allow_gap);
        int gap;
        gap = 0;
        if (allow_gap && $urandom_range(0, 99) < 40)
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 200) : $urandom_range(1, 3);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {o.interest_rate, o.volatility, o.time_to_expiry,
                     o.strike_price, o.spot_price};
        s_tuser  <= {o.is_american, o.is_futures_style, o.is_put};
        do @(posedge aclk); while (!s_tready);
    endtask

    // Let the last accepted word reach the model before counting what is owed.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_prices.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    task automatic write_steps(input logic [4:0] steps);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_data  <= steps;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    function automatic option_t make_option(input bit p, input bit f, input bit a,
                                            input logic [31:0] s, input logic [31:0] k,
                                            input logic [31:0] t, input logic [31:0] v,
                                            input logic [31:0] r);
        option_t o;
        o.is_put = p;
        o.is_futures_style = f;
        o.is_american = a;
        o.spot_price = s;
        o.strike_price = k;
        o.time_to_expiry = t;
        o.volatility = v;
        o.interest_rate = r;
        return o;
    endfunction

    // A market-like option most of the time, otherwise raw noise in every field.
    function automatic option_t random_option();
        option_t o;
        if ($urandom_range(0, 99) < 75) begin
            o = make_option(1'($urandom), 1'($urandom), 1'($urandom),
                            $urandom_range(1, 200) * 65536 + $urandom_range(0, 65535),
                            $urandom_range(1, 200) * 65536 + $urandom_range(0, 65535),
                            $urandom_range(1, 3 * 65536),
                            $urandom_range(0, 65536),
                            32'($urandom_range(0, 13107)) - 32'd3277);
            if ($urandom_range(0, 39) == 0) o.time_to_expiry = 0;
        end else begin
            o = make_option(1'($urandom), 1'($urandom), 1'($urandom), $urandom, $urandom,
                            $urandom, $urandom, $urandom);
        end
        return o;
    endfunction

    // Every kind of option, field extremes and the special cases at the reset setting.
    task automatic test_directed();
        for (int i = 0; i < 8; i++)
            send_option(make_option(i[0], i[1], i[2], 100 << 16, 95 << 16, 65536,
                                    13107, 3277), 1'b1);
        send_option(make_option(1'b0, 1'b0, 1'b0, 100 << 16, 100 << 16, 0, 13107, 3277),
                    1'b1);
        send_option(make_option(1'b0, 1'b0, 1'b0, 100 << 16, 90 << 16, 65536, 0, 3277),
                    1'b1);
        send_option(make_option(1'b1, 1'b0, 1'b1, 100 << 16, 90 << 16, 1, 6, 0), 1'b1);
        send_option(make_option(1'b0, 1'b0, 1'b0, 100 << 16, 90 << 16, 65536, 13107,
                                32'h8000_0000), 1'b1);
        send_option(make_option(1'b1, 1'b1, 1'b1, 100 << 16, 90 << 16, 65536, 13107,
                                32'h7FFF_FFFF), 1'b1);
        send_option(make_option(1'b0, 1'b0, 1'b0, 32'hFFFF_FFFF, 0, 32'hFFFF_FFFF,
                                32'hFFFF_FFFF, 32'h7FFF_FFFF), 1'b1);
        send_option(make_option(1'b1, 1'b0, 1'b1, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                32'hFFFF_FFFF, 32'h8000_0000), 1'b1);
        send_option(make_option(1'b0, 1'b1, 1'b1, 32'hFFFF_0000, 10 << 16, 10 << 16,
                                3 << 16, 65536), 1'b1);
        send_option(make_option(1'b1, 1'b0, 1'b0, 0, 0, 65536, 13107, 3277), 1'b1);
    endtask

    // Steps register extremes, including the values that get clamped.
    task automatic test_steps_extremes();
        logic [4:0] settings[4];
        settings = '{5'd0, 5'd1, 5'd31, 5'd2};
        foreach (settings[i]) begin
            write_steps(settings[i]);
            for (int j = 0; j < 6; j++) send_option(random_option(), 1'b1);
        end
    endtask

    // Result side held off for a long time while options keep coming.
    task automatic test_backpressure();
        write_steps(5'd3);
        hold_off_request = 30000;
        for (int j = 0; j < 6; j++) send_option(random_option(), 1'b0);
        wait_drained();
    endtask

    // Random options over a few settings, small lattices mostly.
    task automatic test_random();
        logic [4:0] steps;
        for (int i = 0; i < RANDOM_OPTIONS; i++) begin
            if (i % 75 == 0) begin
                steps = ($urandom_range(0, 9) == 0) ? 5'd30 : 5'($urandom_range(1, 6));
                if (i == 300) stall_enable = 1'b0;
                if (i == 450) stall_enable = 1'b1;
                write_steps(steps);
            end
            send_option(random_option(), stall_enable);
        end
        wait_drained();
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_steps_extremes();
        test_backpressure();
        test_random();
        repeat (50) @(posedge aclk);
        $display("Priced %0d options and checked %0d result words over steps settings",
                 options_sent, prices_checked);
        $display("0, 1, 2, 3, 30 and 31, with stalls and a long result hold-off.");
        if (error_count == 0 && pending_prices.size() == 0) begin
            $display("binomial_lattice_option_pricer_tb OK");
        end else begin
            $display("binomial_lattice_option_pricer_tb NOT OK");
        end
        $finish;
    end

endmodule

@@ binomial_lattice_option_pricer.f @@
rtl/blop_pkg.sv
rtl/blop_ram.sv
rtl/blop_div.sv
rtl/binomial_lattice_option_pricer.sv
test/binomial_lattice_option_pricer_tb.sv
